/* src/lmsd_pkg.sv */
package lmsd_pkg;

  localparam int FRAME_WORDS       = 512;
  localparam int HALF_WORDS        = FRAME_WORDS / 2;
  localparam int COLUMNS_PER_SHIFT = 64;
  localparam int SCAN_ROWS         = 4;
  localparam int BRIGHTNESS_SLOTS  = 16;

  localparam int PIXEL_W = 12;
  localparam int ADDR_W  = $clog2(FRAME_WORDS);
  localparam int IDX_W   = $clog2(HALF_WORDS);
  localparam int COL_W   = $clog2(COLUMNS_PER_SHIFT);
  localparam int ROW_W   = $clog2(SCAN_ROWS);
  localparam int SLOT_W  = $clog2(BRIGHTNESS_SLOTS);

  localparam int ROW_STRIDE_SHIFT = 5;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_TICK  = 1'b1;

  localparam logic [COL_W-1:0]  LAST_COLUMN = COL_W'(COLUMNS_PER_SHIFT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(BRIGHTNESS_SLOTS - 1);

  // panel wiring order of the shift chain, as offsets inside one row band
  localparam logic [7:0] COLUMN_ORDER [COLUMNS_PER_SHIFT] = '{
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00,
    8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F,
    8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A, 8'h09, 8'h08,
    8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h17, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10,
    8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F,
    8'h1F, 8'h1E, 8'h1D, 8'h1C, 8'h1B, 8'h1A, 8'h19, 8'h18
  };

  // pulse-density patterns, one per 4-bit level
  localparam logic [BRIGHTNESS_SLOTS-1:0] LEVEL_PATTERN [16] = '{
    16'h0000, 16'h0001, 16'h0101, 16'h0111, 16'h1111, 16'h1115, 16'h1515, 16'h1555,
    16'h5555, 16'h555D, 16'h5D5D, 16'h5DDD, 16'h7DDD, 16'h7DDF, 16'h7FDF, 16'h7FFF
  };

  typedef struct packed {
    logic                wr_en;
    logic                wr_half;
    logic [IDX_W-1:0]    wr_idx;
    logic [PIXEL_W-1:0]  wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
  } fs_req_t;

  function automatic logic level_bit(input logic [3:0] level, input logic [SLOT_W-1:0] slot);
    logic [BRIGHTNESS_SLOTS-1:0] pat;
    pat = LEVEL_PATTERN[level];
    return pat[slot];
  endfunction

endpackage

/* src/led_matrix_scan_driver.sv */
// a tick beat's column passes the frame read register, then the output register; writes give no beat
// throughput: one beat per cycle, writes and ticks alike, while out_ready keeps the output moving
// reset: synchronous, clears the scan counters and pipeline, then a clearing pass over all
// 256 entries zeroes both frame banks while in_ready stays low
module led_matrix_scan_driver
  import lmsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [ADDR_W-1:0]  address,
  input  logic [PIXEL_W-1:0] pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   row_select,
  output logic               red_top,
  output logic               green_top,
  output logic               blue_top,
  output logic               red_bottom,
  output logic               green_bottom,
  output logic               blue_bottom,
  output logic               latch_and_show
);

  logic [COL_W-1:0]  column_counter;
  logic [SLOT_W-1:0] slot_counter;
  logic [ROW_W-1:0]  row_counter;

  logic               busy;
  logic [PIXEL_W-1:0] rd_top;
  logic [PIXEL_W-1:0] rd_bottom;
  fs_req_t            req;

  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [SLOT_W-1:0] s1_slot;
  logic              s1_last;
  logic              s1_adv;

  logic             tick_go;
  logic             wr_go;
  logic [IDX_W-1:0] pos;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !busy && (!s1_valid || s1_adv);
  assign tick_go  = in_valid && in_ready && (action == ACTION_TICK);
  assign wr_go    = in_valid && in_ready && (action == ACTION_WRITE);

  // row bands are 32 words apart inside each half
  assign pos = IDX_W'(COLUMN_ORDER[column_counter]
               + ({6'd0, row_counter} << ROW_STRIDE_SHIFT));

  always_comb begin
    req.wr_en   = wr_go;
    req.wr_half = address[ADDR_W-1];
    req.wr_idx  = address[IDX_W-1:0];
    req.wr_data = pixel;
    req.rd_en   = tick_go;
    req.rd_idx  = pos;
  end

  lmsd_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .busy      (busy),
    .rd_top    (rd_top),
    .rd_bottom (rd_bottom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      slot_counter   <= '0;
      row_counter    <= '0;
    end else if (tick_go) begin
      if (column_counter == LAST_COLUMN) begin
        column_counter <= '0;
        if (slot_counter == LAST_SLOT) begin
          slot_counter <= '0;
          row_counter  <= row_counter + 1'b1;
        end else begin
          slot_counter <= slot_counter + 1'b1;
        end
      end else begin
        column_counter <= column_counter + 1'b1;
      end
    end
  end

  // stage 1 waits on the frame read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_go) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_row  <= row_counter;
      s1_slot <= slot_counter;
      s1_last <= (column_counter == LAST_COLUMN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      row_select     <= s1_row;
      red_top        <= level_bit(rd_top[11:8], s1_slot);
      green_top      <= level_bit(rd_top[7:4], s1_slot);
      blue_top       <= level_bit(rd_top[3:0], s1_slot);
      red_bottom     <= level_bit(rd_bottom[11:8], s1_slot);
      green_bottom   <= level_bit(rd_bottom[7:4], s1_slot);
      blue_bottom    <= level_bit(rd_bottom[3:0], s1_slot);
      latch_and_show <= s1_last;
    end
  end

endmodule

/* src/lmsd_frame_store.sv */
module lmsd_frame_store
  import lmsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  fs_req_t            req,
  output logic               busy,
  output logic [PIXEL_W-1:0] rd_top,
  output logic [PIXEL_W-1:0] rd_bottom
);

  // two banks: top half and bottom half share one read index
  logic [PIXEL_W-1:0] bank_top    [HALF_WORDS];
  logic [PIXEL_W-1:0] bank_bottom [HALF_WORDS];

  logic             clearing;
  logic [IDX_W-1:0] clr_idx;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(HALF_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bank_top[clr_idx]    <= '0;
      bank_bottom[clr_idx] <= '0;
    end else if (req.wr_en) begin
      if (req.wr_half) begin
        bank_bottom[req.wr_idx] <= req.wr_data;
      end else begin
        bank_top[req.wr_idx] <= req.wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_top    <= bank_top[req.rd_idx];
      rd_bottom <= bank_bottom[req.rd_idx];
    end
  end

endmodule

/* test/tb.sv */
module tb
  import lmsd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             r_top;
    logic             g_top;
    logic             b_top;
    logic             r_bot;
    logic             g_bot;
    logic             b_bot;
    logic             latch;
  } column_t;

  typedef struct packed {
    logic               act;
    logic [ADDR_W-1:0]  adr;
    logic [PIXEL_W-1:0] pix;
    logic               typed;
    column_t            want;
  } probe_row_t;

  // on/off pattern per 4-bit level, bit n is slot n
  localparam logic [15:0] PDM_PATTERN [16] = '{
    16'h0000, 16'h0001, 16'h0101, 16'h0111, 16'h1111, 16'h1115, 16'h1515, 16'h1555,
    16'h5555, 16'h555D, 16'h5D5D, 16'h5DDD, 16'h7DDD, 16'h7DDF, 16'h7FDF, 16'h7FFF
  };

  localparam column_t DARK = '0;
  localparam column_t LIT  = '{row: '0, r_top: 1'b1, g_top: 1'b1, b_top: 1'b1,
                               r_bot: 1'b1, g_bot: 1'b1, b_bot: 1'b1, latch: 1'b0};

  localparam int PROBE_ROWS = 15;
  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    '{ACTION_TICK,  9'h1FF, 12'hFFF, 1'b1, DARK},  // cleared store, fields of a tick ignored
    '{ACTION_WRITE, 9'h081, 12'hFFF, 1'b0, DARK},
    '{ACTION_WRITE, 9'h181, 12'hFFF, 1'b0, DARK},
    '{ACTION_TICK,  9'h000, 12'h000, 1'b1, LIT},   // column 1, full level on both halves
    '{ACTION_WRITE, 9'h000, 12'hFFF, 1'b0, DARK},
    '{ACTION_WRITE, 9'h1FF, 12'hFFF, 1'b0, DARK},
    '{ACTION_WRITE, 9'h082, 12'h8F1, 1'b0, DARK},
    '{ACTION_WRITE, 9'h182, 12'h5A3, 1'b0, DARK},
    '{ACTION_TICK,  9'h0AA, 12'h555, 1'b0, DARK},
    '{ACTION_WRITE, 9'h083, 12'h000, 1'b0, DARK},
    '{ACTION_TICK,  9'h155, 12'hAAA, 1'b0, DARK},
    '{ACTION_WRITE, 9'h100, 12'hC3E, 1'b0, DARK},
    '{ACTION_WRITE, 9'h084, 12'h7D0, 1'b0, DARK},
    '{ACTION_TICK,  9'h1FF, 12'h000, 1'b0, DARK},
    '{ACTION_TICK,  9'h000, 12'hFFF, 1'b0, DARK}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = ACTION_WRITE;
  logic [ADDR_W-1:0]  address = '0;
  logic [PIXEL_W-1:0] pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ROW_W-1:0]   row_select;
  logic               red_top, green_top, blue_top;
  logic               red_bottom, green_bottom, blue_bottom;
  logic               latch_and_show;

  // travels with the input beat: use the hand-typed column instead of the predicted one
  logic    beat_typed = 1'b0;
  column_t beat_want = '0;

  logic [PIXEL_W-1:0] panel_mem [FRAME_WORDS];
  logic [COL_W-1:0]   scan_col;
  logic [SLOT_W-1:0]  scan_slot;
  logic [ROW_W-1:0]   scan_row;
  column_t            pending_columns [$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 53;
  int holds_wanted = 0;
  int holds_given = 0;
  int hold_left = 0;

  led_matrix_scan_driver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .address(address), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_select(row_select),
    .red_top(red_top), .green_top(green_top), .blue_top(blue_top),
    .red_bottom(red_bottom), .green_bottom(green_bottom), .blue_bottom(blue_bottom),
    .latch_and_show(latch_and_show)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("tb: mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    end
  endtask

  task automatic check_column(input column_t got, input column_t want);
    if (got.row != want.row) report_mismatch("row_select", got.row, want.row);
    if (got.r_top != want.r_top) report_mismatch("red_top", got.r_top, want.r_top);
    if (got.g_top != want.g_top) report_mismatch("green_top", got.g_top, want.g_top);
    if (got.b_top != want.b_top) report_mismatch("blue_top", got.b_top, want.b_top);
    if (got.r_bot != want.r_bot) report_mismatch("red_bottom", got.r_bot, want.r_bot);
    if (got.g_bot != want.g_bot) report_mismatch("green_bottom", got.g_bot, want.g_bot);
    if (got.b_bot != want.b_bot) report_mismatch("blue_bottom", got.b_bot, want.b_bot);
    if (got.latch != want.latch) report_mismatch("latch_and_show", got.latch, want.latch);
  endtask

  // offset of a shift position inside its row band: runs of 8 alternate between
  // the right half counting up and the left half counting down
  function automatic logic [7:0] chain_offset(input logic [COL_W-1:0] col);
    logic [7:0] group_base;
    group_base = {3'b000, col[5:4], 3'b000};
    if (col[3]) return group_base + 8'd15 - {4'b0000, col[3:0]};
    return 8'h80 + group_base + {5'b00000, col[2:0]};
  endfunction

  function automatic logic pdm_bit(input logic [3:0] level);
    logic [15:0] pattern;
    pattern = PDM_PATTERN[level];
    return pattern[scan_slot];
  endfunction

  function automatic column_t shift_column();
    column_t c;
    logic [7:0] band_pos;
    logic [PIXEL_W-1:0] top_px, bot_px;
    band_pos = chain_offset(scan_col) + {scan_row, 5'b00000};
    top_px = panel_mem[{1'b0, band_pos}];
    bot_px = panel_mem[{1'b1, band_pos}];
    c.row = scan_row;
    c.r_top = pdm_bit(top_px[11:8]);
    c.g_top = pdm_bit(top_px[7:4]);
    c.b_top = pdm_bit(top_px[3:0]);
    c.r_bot = pdm_bit(bot_px[11:8]);
    c.g_bot = pdm_bit(bot_px[7:4]);
    c.b_bot = pdm_bit(bot_px[3:0]);
    c.latch = (scan_col == COL_W'(COLUMNS_PER_SHIFT - 1));
    if (c.latch) begin
      scan_col = '0;
      if (scan_slot == SLOT_W'(BRIGHTNESS_SLOTS - 1)) begin
        scan_slot = '0;
        scan_row = scan_row + 1'b1;
      end else begin
        scan_slot = scan_slot + 1'b1;
      end
    end else begin
      scan_col = scan_col + 1'b1;
    end
    return c;
  endfunction

  // input side first so a column accepted at this edge is queued before any check
  always @(posedge clk) begin : track
    column_t got;
    int i;
    if (rst) begin
      for (i = 0; i < FRAME_WORDS; i++) panel_mem[i] = '0;
      scan_col = '0;
      scan_slot = '0;
      scan_row = '0;
      pending_columns.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (action == ACTION_WRITE) begin
          panel_mem[address] = pixel;
        end else begin
          got = shift_column();
          pending_columns.push_back(beat_typed ? beat_want : got);
        end
      end
      if (out_valid && out_ready) begin
        got = '{row: row_select, r_top: red_top, g_top: green_top, b_top: blue_top,
                r_bot: red_bottom, g_bot: green_bottom, b_bot: blue_bottom,
                latch: latch_and_show};
        if (pending_columns.size() == 0) report_mismatch("column beat with none expected", got, 0);
        else check_column(got, pending_columns.pop_front());
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_given != holds_wanted) begin
      out_ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      holds_given++;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic act, input logic [ADDR_W-1:0] adr,
                           input logic [PIXEL_W-1:0] pix, input logic typed,
                           input column_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= adr;
    pixel <= pix;
    beat_typed <= typed;
    beat_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // levels weighted toward the ends of the range
  function automatic logic [3:0] pick_level();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 4'h0;
    if (r == 1) return 4'hF;
    return 4'($urandom);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  task automatic random_burst(input int count);
    int k;
    logic act;
    for (k = 0; k < count; k++) begin
      act = ($urandom_range(99) < 70) ? ACTION_TICK : ACTION_WRITE;
      send_beat(act, ADDR_W'($urandom), random_pixel(), 1'b0, DARK);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_columns.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < PROBE_ROWS; n++) begin
      send_beat(PROBES[n].act, PROBES[n].adr, PROBES[n].pix, PROBES[n].typed, PROBES[n].want);
    end
    random_burst(400);
    wait_drained();

    send_idle_pct = 53;
    recv_idle_pct = 27;
    random_burst(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_wanted++;
    random_burst(350);

    // fresh picture, then one full shift line of ticks over it
    for (n = 0; n < FRAME_WORDS; n++) begin
      send_beat(ACTION_WRITE, ADDR_W'(n), random_pixel(), 1'b0, DARK);
    end
    for (n = 0; n < COLUMNS_PER_SHIFT; n++) begin
      send_beat(ACTION_TICK, ADDR_W'($urandom), PIXEL_W'($urandom), 1'b0, DARK);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
